// ===== rtl/core/http_syntax_validator_defines.svh =====
// assertion macros for the http syntax validator checker
// no dependencies; take in with `include by bare file name
`ifndef HTTP_SYNTAX_VALIDATOR_DEFINES_SVH
`define HTTP_SYNTAX_VALIDATOR_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define HSV_ASSERT_CLK(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("http_syntax_validator assertion failed");

// same, on the clk and rst_n of the enclosing scope
`define HSV_ASSERT(lbl, prop) `HSV_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

// ===== rtl/core/hsv_pkg.sv =====
// shared types, constants and byte classification for the http syntax validator
// no dependencies
package hsv_pkg;

    // rule selection codes
    localparam logic [2:0] MODE_TOKEN   = 3'd0;
    localparam logic [2:0] MODE_SEGMENT = 3'd1;
    localparam logic [2:0] MODE_QUERY   = 3'd2;
    localparam logic [2:0] MODE_FIELD   = 3'd3;
    localparam logic [2:0] MODE_HOST    = 3'd4;

    // characters and limits
    localparam logic [7:0]  CHR_PERCENT     = 8'h25;
    localparam logic [7:0]  CHR_COLON       = 8'h3A;
    localparam logic [7:0]  CHR_SLASH       = 8'h2F;
    localparam logic [7:0]  CHR_QUESTION    = 8'h3F;
    localparam logic [7:0]  CHR_TAB         = 8'h09;
    localparam logic [7:0]  VISIBLE_MIN     = 8'h21;
    localparam logic [7:0]  MIDDLE_MIN      = 8'h20;
    localparam logic [1:0]  HEX_ESC_DIGITS  = 2'd2;
    localparam logic [16:0] PORT_MAX        = 17'h0ffff;
    localparam logic [16:0] PORT_SAT        = 17'h1ffff;
    localparam logic [2:0]  PORT_DIGITS_MAX = 3'd5;
    localparam logic [2:0]  PORT_DIGITS_SAT = 3'd6;

    // decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef struct packed {
        logic       tchar;
        logic       pchar;
        logic       sub_unres;
        logic       slash_q;
        logic       hex;
        logic       digit;
        logic       percent;
        logic       colon;
        logic       visible;
        logic       middle_ok;
        logic [3:0] digit_val;
    } byte_class_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        no_byte;
        logic        last;
        byte_class_t cls;
    } item_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        logic        is_alpha;
        logic        tchar_sp;
        logic        sub_sp;
        c         = '0;
        c.digit   = (b >= 8'h30) && (b <= 8'h39);
        is_alpha  = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
        c.hex     = c.digit || ((b >= 8'h61) && (b <= 8'h66)) ||
                    ((b >= 8'h41) && (b <= 8'h46));
        case (b) inside
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: tchar_sp = 1'b1;
            default:                                        tchar_sp = 1'b0;
        endcase
        case (b) inside
            8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26, 8'h27,
            8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: sub_sp = 1'b1;
            default:                                        sub_sp = 1'b0;
        endcase
        c.tchar     = c.digit || is_alpha || tchar_sp;
        c.sub_unres = c.digit || is_alpha || sub_sp;
        c.pchar     = c.sub_unres || (b == CHR_COLON) || (b == 8'h40);
        c.slash_q   = (b == CHR_SLASH) || (b == CHR_QUESTION);
        c.percent   = (b == CHR_PERCENT);
        c.colon     = (b == CHR_COLON);
        c.visible   = (b >= VISIBLE_MIN);
        c.middle_ok = (b >= MIDDLE_MIN) || (b == CHR_TAB);
        c.digit_val = b[3:0];
        return c;
    endfunction

endpackage

// ===== rtl/core/hsv_if.sv =====
// handshake channel interfaces for the http syntax validator
// no dependencies
interface hsv_str_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       no_byte;
    logic       last;

    modport source (output valid, data_byte, no_byte, last, input ready);
    modport sink   (input valid, data_byte, no_byte, last, output ready);
endinterface

interface hsv_res_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, valid_res, input ready);
    modport sink   (input valid, valid_res, output ready);
endinterface

interface hsv_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] rule_mode;

    modport source (output valid, rule_mode, input ready);
    modport sink   (input valid, rule_mode, output ready);
endinterface

// ===== rtl/core/hsv_front.sv =====
// front end: mode register, byte transfer and classification into queue items
// depends on hsv_pkg and hsv_if
module hsv_front (
    input  logic           clk,
    input  logic           rst_n,
    hsv_cfg_if.sink        cfg,
    hsv_str_if.sink        str,
    output logic           q_push,
    output hsv_pkg::item_t q_item,
    input  logic           q_full
);
    import hsv_pkg::*;

    logic [2:0] rule_mode_reg;
    logic [2:0] rule_mode_next;

    assign cfg.ready = 1'b1;
    assign str.ready = !q_full;

    always_comb
    begin
        rule_mode_next = rule_mode_reg;
        if (cfg.valid && cfg.ready)
        begin
            rule_mode_next = cfg.rule_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_mode_reg <= MODE_TOKEN;
        end
        else
        begin
            rule_mode_reg <= rule_mode_next;
        end
    end

    // each byte is tagged with the mode in force when it arrives
    assign q_push         = str.valid && str.ready;
    assign q_item.mode    = rule_mode_reg;
    assign q_item.no_byte = str.no_byte;
    assign q_item.last    = str.last;
    assign q_item.cls     = classify(str.data_byte);
endmodule

// ===== rtl/core/hsv_queue.sv =====
// small flop-based fifo between front and back
// depends on hsv_pkg
module hsv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hsv_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output hsv_pkg::item_t pop_item,
    output logic           empty
);
    import hsv_pkg::*;

    localparam logic [QUEUE_AW-1:0] PTR_LAST  = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_AW:0]   COUNT_MAX = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    item_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == COUNT_MAX);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end
endmodule

// ===== rtl/core/hsv_back.sv =====
// back end: per-string rule state, final verdict and output register
// depends on hsv_pkg and hsv_if
module hsv_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hsv_pkg::item_t q_item,
    input  logic           q_empty,
    output logic           q_pop,
    hsv_res_if.source      res
);
    import hsv_pkg::*;

    logic        failed_reg,         failed_next;
    logic [1:0]  hex_pending_reg,    hex_pending_next;
    logic        seen_byte_reg,      seen_byte_next;
    logic        prev_visible_reg,   prev_visible_next;
    logic        prev_middle_ok_reg, prev_middle_ok_next;
    logic        in_port_reg,        in_port_next;
    logic        host_nonempty_reg,  host_nonempty_next;
    logic [16:0] port_value_reg,     port_value_next;
    logic [2:0]  port_digits_reg,    port_digits_next;
    logic        out_valid_reg,      out_valid_next;
    logic        out_res_reg,        out_res_next;

    byte_class_t c;
    logic        esc_active;
    logic        esc_consumed;
    logic        esc_fail;
    logic [1:0]  esc_pending;
    logic [20:0] port_mul;
    logic [16:0] port_sat;
    logic        verdict;

    // a result only moves out when the output register is free or draining
    assign q_pop = !q_empty && (!q_item.last || !out_valid_reg || res.ready);
    assign c     = q_item.cls;

    // percent escape handling shared by segment, query and host
    assign esc_active   = (hex_pending_reg != 2'd0);
    assign esc_consumed = esc_active || c.percent;
    assign esc_fail     = esc_active && !c.hex;
    assign esc_pending  = esc_active ? hex_pending_reg - 2'd1 :
                          (c.percent ? HEX_ESC_DIGITS : hex_pending_reg);

    // port accumulate: value * 10 + digit, saturating
    assign port_mul = ({4'b0, port_value_reg} << 3) + ({4'b0, port_value_reg} << 1) +
                      {17'b0, c.digit_val};
    assign port_sat = (port_mul > {4'b0, PORT_SAT}) ? PORT_SAT : port_mul[16:0];

    always_comb
    begin
        failed_next         = failed_reg;
        hex_pending_next    = hex_pending_reg;
        seen_byte_next      = seen_byte_reg;
        prev_visible_next   = prev_visible_reg;
        prev_middle_ok_next = prev_middle_ok_reg;
        in_port_next        = in_port_reg;
        host_nonempty_next  = host_nonempty_reg;
        port_value_next     = port_value_reg;
        port_digits_next    = port_digits_reg;
        verdict             = 1'b0;

        if (!q_item.no_byte)
        begin
            unique case (q_item.mode)
                MODE_TOKEN:
                begin
                    if (!c.tchar)
                    begin
                        failed_next = 1'b1;
                    end
                end
                MODE_SEGMENT, MODE_QUERY:
                begin
                    hex_pending_next = esc_pending;
                    if (esc_consumed)
                    begin
                        if (esc_fail)
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (!c.pchar && !((q_item.mode == MODE_QUERY) && c.slash_q))
                    begin
                        failed_next = 1'b1;
                    end
                end
                MODE_FIELD:
                begin
                    if (!seen_byte_reg)
                    begin
                        if (!c.visible)
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (!prev_middle_ok_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    prev_visible_next   = c.visible;
                    prev_middle_ok_next = c.middle_ok;
                end
                MODE_HOST:
                begin
                    if (in_port_reg)
                    begin
                        if (c.digit)
                        begin
                            port_value_next = port_sat;
                            if (port_digits_reg < PORT_DIGITS_SAT)
                            begin
                                port_digits_next = port_digits_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (!esc_active && c.colon)
                    begin
                        in_port_next = 1'b1;
                    end
                    else
                    begin
                        host_nonempty_next = 1'b1;
                        hex_pending_next   = esc_pending;
                        if (esc_consumed)
                        begin
                            if (esc_fail)
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        else if (!c.sub_unres)
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            seen_byte_next = 1'b1;
        end

        // verdict on the state after this item
        if (!failed_next)
        begin
            unique case (q_item.mode)
                MODE_TOKEN:               verdict = seen_byte_next;
                MODE_SEGMENT, MODE_QUERY: verdict = (hex_pending_next == 2'd0);
                MODE_FIELD:               verdict = !seen_byte_next || prev_visible_next;
                MODE_HOST:
                begin
                    if (!host_nonempty_next || (hex_pending_next != 2'd0))
                    begin
                        verdict = 1'b0;
                    end
                    else if (!in_port_next)
                    begin
                        verdict = 1'b1;
                    end
                    else
                    begin
                        verdict = (port_digits_next >= 3'd1) &&
                                  (port_digits_next <= PORT_DIGITS_MAX) &&
                                  (port_value_next >= 17'd1) &&
                                  (port_value_next <= PORT_MAX);
                    end
                end
                default:                  verdict = 1'b0;
            endcase
        end

        // end of string: clear running state
        if (q_item.last)
        begin
            failed_next         = 1'b0;
            hex_pending_next    = 2'd0;
            seen_byte_next      = 1'b0;
            prev_visible_next   = 1'b0;
            prev_middle_ok_next = 1'b0;
            in_port_next        = 1'b0;
            host_nonempty_next  = 1'b0;
            port_value_next     = '0;
            port_digits_next    = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (q_pop && q_item.last)
        begin
            out_valid_next = 1'b1;
            out_res_next   = verdict;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg         <= 1'b0;
            hex_pending_reg    <= 2'd0;
            seen_byte_reg      <= 1'b0;
            prev_visible_reg   <= 1'b0;
            prev_middle_ok_reg <= 1'b0;
            in_port_reg        <= 1'b0;
            host_nonempty_reg  <= 1'b0;
            port_value_reg     <= '0;
            port_digits_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                failed_reg         <= failed_next;
                hex_pending_reg    <= hex_pending_next;
                seen_byte_reg      <= seen_byte_next;
                prev_visible_reg   <= prev_visible_next;
                prev_middle_ok_reg <= prev_middle_ok_next;
                in_port_reg        <= in_port_next;
                host_nonempty_reg  <= host_nonempty_next;
                port_value_reg     <= port_value_next;
                port_digits_reg    <= port_digits_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.valid_res = out_res_reg;
endmodule

// ===== rtl/core/http_syntax_validator.sv =====
// top level of the http syntax validator: front end, queue and back end
// depends on hsv_pkg, hsv_if, hsv_front, hsv_queue and hsv_back
//
// Checks a string, one byte per transfer on str, against the rule held in
// the rule_mode register (token, uri segment, uri query, field line or host
// header) and gives one transfer on res with valid_res on the item marked
// last. The block takes one byte per clock cycle, sustained, as long as res
// keeps up; the last byte's item passes through the two-entry queue between
// the classifying front end and the back end that updates the per-string
// state, and its verdict is offered on res from the back end's output
// register, held there until it transfers.
// str.ready drops only when a verdict has waited on res and the queue has
// filled behind it. The cfg channel is always ready; write it only while no
// string is in flight. The per-string state clears after every last item.
module http_syntax_validator (
    input  logic      clk,
    input  logic      rst_n,
    hsv_cfg_if.sink   cfg,
    hsv_str_if.sink   str,
    hsv_res_if.source res
);
    import hsv_pkg::*;

    // front to queue
    logic  q_push;
    item_t q_push_item;
    logic  q_full;

    // queue to back
    logic  q_pop;
    item_t q_pop_item;
    logic  q_empty;

    // mode register, byte transfer and classification
    hsv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .str    (str),
        .q_push (q_push),
        .q_item (q_push_item),
        .q_full (q_full)
    );

    // decouples byte intake from result back-pressure
    hsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    // rule state, verdict and output register
    hsv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_pop_item),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .res     (res)
    );
endmodule

// ===== rtl/core/hsv_checker.sv =====
// port-level assertions for the http syntax validator, bound to the top level
// depends on http_syntax_validator_defines.svh and http_syntax_validator
`include "http_syntax_validator_defines.svh"

module hsv_checker (
    input logic clk,
    input logic rst_n,
    input logic str_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_valid_res,
    input logic cfg_ready
);
    // a stalled verdict holds
    `HSV_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res_valid_res)))
    // a verdict leaves only by a transfer
    `HSV_ASSERT(a_res_drop, $fell(res_valid) |-> $past(res_ready))
    // byte intake stalls only behind a verdict that waited
    `HSV_ASSERT(a_str_stall, !str_ready |-> $past(res_valid && !res_ready))
    // the mode register never pushes back
    `HSV_ASSERT(a_cfg_ready, cfg_ready)
endmodule

bind http_syntax_validator hsv_checker u_hsv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .str_ready     (str.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_valid_res (res.valid_res),
    .cfg_ready     (cfg.ready)
);

// ===== tb/testbench.sv =====
// self-checking testbench for http_syntax_validator: drives strings, predicts each verdict
// depends on hsv_pkg (mode codes, character constants), hsv_if and the rtl top level
module testbench;
    import hsv_pkg::*;

    // mode codes with no rule behind them
    localparam logic [2:0] MODE_UNUSED_LOW = 3'd5;
    localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;

    localparam int CLK_HALF      = 5;
    localparam int IDLE_PCT      = 10;
    localparam int LONG_STALL    = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 800;
    localparam int CYCLE_LIMIT   = 200000;

    // character pools for well-formed content
    localparam string TOKEN_CHARS = "abzAXZ0579!#$%&'*+-.^_|~";
    localparam string SUB_CHARS   = "abzAXZ0579-._~!$&'()*+,;=";
    localparam string HEX_CHARS   = "0123456789abcdefABCDEF";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_byte;
        logic       last;
    } str_item_t;

    logic clk;
    logic rst_n;

    hsv_cfg_if cfg ();
    hsv_str_if str ();
    hsv_res_if res ();

    http_syntax_validator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .str   (str),
        .res   (res)
    );

    // items waiting for the driver, verdicts waiting for the monitor
    str_item_t  pending_items[$];
    bit         pending_verdicts[$];
    logic [7:0] word_buf[$];

    // predictor copy of the rule register and of the per-string scan state
    logic [2:0]  active_mode;
    bit          scan_bad;
    logic [1:0]  hex_owed;
    bit          any_byte;
    bit          last_visible;
    bit          last_middle_ok;
    bit          port_phase;
    bit          host_seen;
    logic [16:0] port_acc;
    logic [2:0]  port_len;

    // run control shared by the processes
    bit quiet;
    bit hold_sender;
    bit long_stall_req;
    int stall_left;
    int cycles;
    int mismatches;
    int items_pushed;
    int items_accepted;
    int bytes_queued;
    int strings_seen;
    int verdicts_true;
    int modes_written;

    // ------------------------------------------------------------------
    // byte classes
    // ------------------------------------------------------------------
    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_hexdig(logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    // 8'h60 is the backquote
    function automatic bit is_tchar(logic [7:0] b);
        return is_digit(b) || is_alpha(b) ||
               b inside {"!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_",
                         8'h60, "|", "~"};
    endfunction

    function automatic bit is_reg_char(logic [7:0] b);
        return is_digit(b) || is_alpha(b) ||
               b inside {"-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+",
                         ",", ";", "="};
    endfunction

    function automatic bit is_pchar(logic [7:0] b);
        return is_reg_char(b) || b == CHR_COLON || b == "@";
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_scan();
        scan_bad       = 1'b0;
        hex_owed       = '0;
        any_byte       = 1'b0;
        last_visible   = 1'b0;
        last_middle_ok = 1'b0;
        port_phase     = 1'b0;
        host_seen      = 1'b0;
        port_acc       = '0;
        port_len       = '0;
    endfunction

    // percent escape bookkeeping; returns 1 when the byte belongs to an escape
    function automatic bit take_escape(logic [7:0] b);
        if (hex_owed != 0) begin
            if (!is_hexdig(b))
                scan_bad = 1'b1;
            hex_owed = hex_owed - 2'd1;
            return 1'b1;
        end
        if (b == CHR_PERCENT) begin
            hex_owed = HEX_ESC_DIGITS;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        int unsigned acc;
        bit          consumed;
        case (active_mode)
            MODE_TOKEN: begin
                if (!is_tchar(b))
                    scan_bad = 1'b1;
            end
            MODE_SEGMENT, MODE_QUERY: begin
                consumed = take_escape(b);
                if (!consumed && !is_pchar(b) &&
                    !(active_mode == MODE_QUERY && (b == CHR_SLASH || b == CHR_QUESTION)))
                    scan_bad = 1'b1;
            end
            MODE_FIELD: begin
                // first byte must be visible, any later byte needs an acceptable predecessor
                if (!any_byte) begin
                    if (b < VISIBLE_MIN)
                        scan_bad = 1'b1;
                end
                else if (!last_middle_ok) begin
                    scan_bad = 1'b1;
                end
                last_visible   = b >= VISIBLE_MIN;
                last_middle_ok = b >= MIDDLE_MIN || b == CHR_TAB;
            end
            MODE_HOST: begin
                if (port_phase) begin
                    if (is_digit(b)) begin
                        // saturating decimal accumulation
                        acc = port_acc * 10 + (b - 8'h30);
                        if (acc > PORT_SAT)
                            acc = PORT_SAT;
                        port_acc = acc[16:0];
                        if (port_len < PORT_DIGITS_SAT)
                            port_len = port_len + 3'd1;
                    end
                    else begin
                        scan_bad = 1'b1;
                    end
                end
                else if (hex_owed == 0 && b == CHR_COLON) begin
                    port_phase = 1'b1;
                end
                else begin
                    host_seen = 1'b1;
                    consumed  = take_escape(b);
                    if (!consumed && !is_reg_char(b))
                        scan_bad = 1'b1;
                end
            end
            default: ;
        endcase
        any_byte = 1'b1;
    endfunction

    function automatic bit string_verdict();
        if (scan_bad)
            return 1'b0;
        case (active_mode)
            MODE_TOKEN:               return any_byte;
            MODE_SEGMENT, MODE_QUERY: return hex_owed == 0;
            MODE_FIELD:               return !any_byte || last_visible;
            MODE_HOST: begin
                if (!host_seen || hex_owed != 0)
                    return 1'b0;
                if (!port_phase)
                    return 1'b1;
                return port_len >= 1 && port_len <= PORT_DIGITS_MAX &&
                       port_acc >= 1 && port_acc <= PORT_MAX;
            end
            default:                  return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and known values on every input from time zero
    // ------------------------------------------------------------------
    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg.valid       = 1'b0;
        cfg.rule_mode   = '0;
        str.valid       = 1'b0;
        str.data_byte   = '0;
        str.no_byte     = 1'b0;
        str.last        = 1'b0;
        res.ready       = 1'b0;
        active_mode     = MODE_TOKEN;
        clear_scan();
        forever #CLK_HALF clk = ~clk;
    end

    // run limit, counted in clock cycles
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("http_syntax_validator regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // string driver: predicts on every accepted transfer, then offers the next item
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        str_item_t nxt;
        if (!rst_n) begin
            str.valid <= 1'b0;
        end
        else begin
            // a rule write is to land only while nothing is in flight; not enforced here
            if (cfg.valid && cfg.ready)
                active_mode = cfg.rule_mode;

            if (str.valid && str.ready) begin
                if (!str.no_byte)
                    scan_byte(str.data_byte);
                if (str.last) begin
                    pending_verdicts.push_back(string_verdict());
                    clear_scan();
                    strings_seen++;
                end
                items_accepted++;
            end

            // the current item stays put until its transfer
            if (!str.valid || str.ready) begin
                if (pending_items.size() != 0 && !hold_sender &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = pending_items.pop_front();
                    str.valid     <= 1'b1;
                    str.data_byte <= nxt.data_byte;
                    str.no_byte   <= nxt.no_byte;
                    str.last      <= nxt.last;
                end
                else begin
                    str.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // verdict receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            res.ready <= 1'b0;
        end
        else if (stall_left != 0) begin
            res.ready <= 1'b0;
            stall_left--;
        end
        else if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left     = LONG_STALL;
            res.ready     <= 1'b0;
        end
        else begin
            res.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // verdict monitor: every transfer on res is matched against the oldest prediction
    always @(posedge clk) begin
        bit want;
        if (rst_n && res.valid && res.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("valid_res: expected nothing, actual %0b", res.valid_res);
                mismatches++;
            end
            else begin
                want = pending_verdicts.pop_front();
                if (res.valid_res !== want) begin
                    $error("valid_res: expected %0b, actual %0b", want, res.valid_res);
                    mismatches++;
                end
                if (want)
                    verdicts_true++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [7:0] d, input bit nb, input bit lst);
        str_item_t it;
        it.data_byte = d;
        it.no_byte   = nb;
        it.last      = lst;
        pending_items.push_back(it);
        items_pushed++;
        // a no-byte item that does not end a string is merely skipped by the block
        if (!(nb && !lst))
            bytes_queued++;
    endtask

    // literal text; an empty closed string goes out as a single no-byte item
    task automatic push_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0, close && i == s.len() - 1);
        if (s.len() == 0 && close)
            push_item(8'h00, 1'b1, 1'b1);
    endtask

    // sends word_buf as one string, with a stray skipped item now and then
    task automatic push_word();
        if (word_buf.size() == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
        else begin
            foreach (word_buf[i]) begin
                if ($urandom_range(0, 15) == 0)
                    push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                push_item(word_buf[i], 1'b0, i == word_buf.size() - 1);
            end
        end
    endtask

    task automatic push_pick(input string pool);
        word_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    endtask

    task automatic push_escape();
        word_buf.push_back(CHR_PERCENT);
        push_pick(HEX_CHARS);
        push_pick(HEX_CHARS);
    endtask

    // one random string for the given rule: mostly well formed, the rest broken
    task automatic build_word(input logic [2:0] m);
        int    len;
        int    n;
        string digits;
        word_buf.delete();
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        case (m)
            MODE_TOKEN: begin
                repeat (len) push_pick(TOKEN_CHARS);
            end
            MODE_SEGMENT, MODE_QUERY: begin
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0)
                        push_escape();
                    else if (m == MODE_QUERY && $urandom_range(0, 4) == 0)
                        word_buf.push_back($urandom_range(0, 1) ? CHR_SLASH : CHR_QUESTION);
                    else if ($urandom_range(0, 5) == 0)
                        word_buf.push_back($urandom_range(0, 1) ? CHR_COLON : 8'h40);
                    else
                        push_pick(SUB_CHARS);
                end
            end
            MODE_FIELD: begin
                for (int k = 0; k < len; k++) begin
                    if (k == 0 || k == len - 1)
                        word_buf.push_back(8'($urandom_range(8'h21, 8'hff)));
                    else if ($urandom_range(0, 7) == 0)
                        word_buf.push_back(CHR_TAB);
                    else
                        word_buf.push_back(8'($urandom_range(8'h20, 8'hff)));
                end
            end
            MODE_HOST: begin
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 5) == 0)
                        push_escape();
                    else
                        push_pick(SUB_CHARS);
                end
                if ($urandom_range(0, 1)) begin
                    word_buf.push_back(CHR_COLON);
                    // ports in range, on the limits, too large and too long
                    case ($urandom_range(0, 3))
                        0: digits = $sformatf("%0d", $urandom_range(1, 65535));
                        1: begin
                            case ($urandom_range(0, 3))
                                0: digits = "0";
                                1: digits = "65535";
                                2: digits = "65536";
                                default: digits = "00080";
                            endcase
                        end
                        2: begin
                            digits = "";
                            n = $urandom_range(0, 7);
                            repeat (n) digits = $sformatf("%s%0d", digits, $urandom_range(0, 9));
                        end
                        default: digits = $sformatf("%0d", $urandom_range(0, 200000));
                    endcase
                    for (int k = 0; k < digits.len(); k++)
                        word_buf.push_back(digits[k]);
                end
            end
            default: begin
                repeat (len) word_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase

        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    if (word_buf.size() != 0)
                        word_buf[$urandom_range(0, word_buf.size() - 1)] =
                            8'($urandom_range(0, 255));
                    else
                        word_buf.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    word_buf.delete();
                    repeat ($urandom_range(0, 6)) word_buf.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    // escape cut short, or a colon where a hex digit is owed
                    word_buf.push_back(CHR_PERCENT);
                    case ($urandom_range(0, 2))
                        0: ;
                        1: push_pick(HEX_CHARS);
                        default: word_buf.push_back(CHR_COLON);
                    endcase
                end
            endcase
        end
        push_word();
    endtask

    // rule register write; called only once the block has gone quiet
    task automatic write_mode(input logic [2:0] m);
        @(posedge clk);
        cfg.valid     <= 1'b1;
        cfg.rule_mode <= m;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        modes_written++;
    endtask

    // every queued item transferred and every verdict back, then let the pipe empty
    task automatic wait_idle();
        do @(posedge clk); while (items_accepted != items_pushed || pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int         phase;
        int         quota;
        int         start_bytes;
        int         directed_bytes;
        logic [2:0] m;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part, first under the reset rule (token)
        push_text("a~", 1'b1);
        push_text("", 1'b1);                  // empty token is invalid
        push_item(8'h00, 1'b1, 1'b0);         // skipped item inside a string
        push_item(8'hff, 1'b0, 1'b1);         // high byte is no tchar
        push_item(8'h00, 1'b0, 1'b1);
        wait_idle();

        write_mode(MODE_SEGMENT);
        push_text("%4", 1'b1);                // escape cut off by the end
        push_text(":@", 1'b1);
        push_text("", 1'b1);                  // empty segment is fine
        wait_idle();

        write_mode(MODE_QUERY);
        push_text("/?%7E", 1'b1);
        wait_idle();

        write_mode(MODE_FIELD);
        push_text(" a", 1'b1);                // leading space
        push_text("a\tb", 1'b1);              // tab in the middle
        push_item(8'h80, 1'b0, 1'b1);         // high byte counts as visible
        push_text("a\t", 1'b1);               // trailing tab
        push_text("", 1'b1);
        push_text("!", 1'b0);                 // rule change in mid-string follows
        wait_idle();

        write_mode(MODE_HOST);
        push_text(":8", 1'b1);                // host part seen under another rule: empty
        push_text("h:65535", 1'b1);
        wait_idle();

        write_mode(MODE_UNUSED_TOP);
        push_text("a", 1'b1);                 // unused code never passes
        wait_idle();
        directed_bytes = bytes_queued;

        // random phases, each under one rule setting
        phase = 0;
        while (bytes_queued - directed_bytes < RANDOM_BYTES) begin
            if (phase < 5)
                m = 3'(phase);
            else if ($urandom_range(0, 9) == 0)
                m = 3'($urandom_range(MODE_UNUSED_LOW, MODE_UNUSED_TOP));
            else
                m = 3'($urandom_range(MODE_TOKEN, MODE_HOST));
            write_mode(m);
            quota       = (m > MODE_HOST) ? 8 : $urandom_range(40, 100);
            start_bytes = bytes_queued;
            quiet       = (phase == 2);

            while (bytes_queued - start_bytes < quota / 2)
                build_word(m);

            // receiver holds off while the sender keeps offering, so the block backs up
            if (phase == 3)
                long_stall_req = 1'b1;

            // sender waits for every outstanding verdict before going on
            if (phase == 4) begin
                hold_sender = 1'b1;
                do @(posedge clk); while (str.valid || pending_verdicts.size() != 0);
                hold_sender = 1'b0;
            end

            while (bytes_queued - start_bytes < quota)
                build_word(m);
            wait_idle();
            quiet = 1'b0;
            phase++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d strings, %0d of them valid, over %0d transfers on str",
                 strings_seen, verdicts_true, items_accepted);
        $display("rule register written %0d times across %0d random phases",
                 modes_written, phase);
        if (mismatches == 0)
            $display("http_syntax_validator regression: pass");
        else
            $display("http_syntax_validator regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hsv_pkg.sv
rtl/core/hsv_if.sv
rtl/core/hsv_front.sv
rtl/core/hsv_queue.sv
rtl/core/hsv_back.sv
rtl/core/http_syntax_validator.sv
rtl/core/hsv_checker.sv
tb/testbench.sv
